// ===== hdl/psb_pkg.sv =====
// Shared types, constants and codes for the particle step with triangle bounce.
package psb_pkg;

   localparam int COMP_BITS  = 20;
   localparam int LIFE_BITS  = 20;
   localparam int VEC_BITS   = 3 * COMP_BITS;
   localparam int HIT_BITS   = 7;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 20;

   localparam int SQRT_STEPS = 31;
   localparam int DIV_STEPS  = 13;
   localparam int CNT_BITS   = 5;

   localparam logic [CSR_IDX_BITS-1:0] CSR_TIME_STEP        = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GRAVITY_Y        = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOUNCE_DAMPING   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PARALLEL_EPSILON = 2'd3;

   localparam logic [15:0]        TIME_STEP_RST   = 16'd1092;
   localparam logic signed [19:0] GRAVITY_Y_RST   = -20'sd16384;
   localparam logic [15:0]        DAMPING_RST     = 16'd45875;
   localparam logic [11:0]        EPSILON_RST     = 12'd1;

   typedef struct packed {
      logic                        req_type;
      logic [VEC_BITS-1:0]         corner_a;
      logic [VEC_BITS-1:0]         corner_b;
      logic [VEC_BITS-1:0]         corner_c;
      logic [VEC_BITS-1:0]         position;
      logic [VEC_BITS-1:0]         velocity;
      logic signed [LIFE_BITS-1:0] lifetime;
   } req_item_type;

   typedef struct packed {
      logic [VEC_BITS-1:0]         new_position;
      logic [VEC_BITS-1:0]         new_velocity;
      logic signed [LIFE_BITS-1:0] new_lifetime;
      logic [HIT_BITS-1:0]         hit_count;
      logic                        status;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0]        time_step;
      logic signed [19:0] gravity_y;
      logic [15:0]        bounce_damping;
      logic [11:0]        parallel_epsilon;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NOP, OP_APPEND, OP_MOVE, OP_GRAV, OP_DD, OP_SQ_LOAD, OP_SQ_STEP, OP_LEN,
      OP_TRI_FIRST, OP_RD, OP_EDGE, OP_CRP, OP_CRQ, OP_DET, OP_UU, OP_VV, OP_TT,
      OP_TEST, OP_CRC, OP_NORM, OP_SS, OP_LL, OP_DIV_LOAD, OP_DIV_STEP, OP_DIV_END,
      OP_KK, OP_REFL, OP_NEXT, OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] idx;
      logic       ph;
   } cmd_type;

   typedef struct packed {
      logic is_step;
      logic acc_zero;
      logic hit;
      logic norm_big;
      logic tri_more;
   } stat_type;

endpackage

// ===== hdl/psb_ctrl.sv =====
// Sequencer for the particle step: walks the datapath through each operation.
module psb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  psb_pkg::stat_type stat,
   output psb_pkg::cmd_type  cmd,
   output logic              busy
);
   import psb_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DISP, S_APPEND, S_MOVE, S_GRAV, S_DD, S_SQL, S_SQS, S_LEN, S_TRI0,
      S_RD, S_EDGE, S_CRP, S_CRQ, S_DET, S_UU, S_VV, S_TT, S_TEST, S_CRC, S_NORM,
      S_SS, S_NSQL, S_NSQS, S_LL, S_DVL, S_DVS, S_DVE, S_KK, S_REFL, S_NEXT, S_FIN
   } state_type;

   state_type             state_ff, state_in;
   logic [1:0]            idx_ff, idx_in, idx_step;
   logic                  ph_ff, ph_in, idx_wrap;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   cmd_type               cmd_ff;
   logic                  busy_ff;

   function automatic dp_op_type op_of(input state_type s);
      case (s)
         S_APPEND: return OP_APPEND;
         S_MOVE:   return OP_MOVE;
         S_GRAV:   return OP_GRAV;
         S_DD:     return OP_DD;
         S_SQL:    return OP_SQ_LOAD;
         S_SQS:    return OP_SQ_STEP;
         S_LEN:    return OP_LEN;
         S_TRI0:   return OP_TRI_FIRST;
         S_RD:     return OP_RD;
         S_EDGE:   return OP_EDGE;
         S_CRP:    return OP_CRP;
         S_CRQ:    return OP_CRQ;
         S_DET:    return OP_DET;
         S_UU:     return OP_UU;
         S_VV:     return OP_VV;
         S_TT:     return OP_TT;
         S_TEST:   return OP_TEST;
         S_CRC:    return OP_CRC;
         S_NORM:   return OP_NORM;
         S_SS:     return OP_SS;
         S_NSQL:   return OP_SQ_LOAD;
         S_NSQS:   return OP_SQ_STEP;
         S_LL:     return OP_LL;
         S_DVL:    return OP_DIV_LOAD;
         S_DVS:    return OP_DIV_STEP;
         S_DVE:    return OP_DIV_END;
         S_KK:     return OP_KK;
         S_REFL:   return OP_REFL;
         S_NEXT:   return OP_NEXT;
         S_FIN:    return OP_FINISH;
         default:  return OP_NOP;
      endcase
   endfunction

   assign idx_step = idx_ff + 2'd1;
   assign idx_wrap = (idx_ff == 2'd2);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ph_in    = ph_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE:   if (start) state_in = S_DISP;
         S_DISP:   state_in = stat.is_step ? S_MOVE : S_APPEND;
         S_APPEND: state_in = S_IDLE;
         S_MOVE: begin
            idx_in = idx_wrap ? 2'd0 : idx_step;
            if (idx_wrap) state_in = S_GRAV;
         end
         S_GRAV:   state_in = S_DD;
         S_DD: begin
            idx_in = idx_wrap ? 2'd0 : idx_step;
            if (idx_wrap) state_in = S_SQL;
         end
         S_SQL: begin
            cnt_in   = '0;
            state_in = stat.acc_zero ? S_FIN : S_SQS;
         end
         S_SQS: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(SQRT_STEPS - 1)) state_in = S_LEN;
         end
         S_LEN:    state_in = S_TRI0;
         S_TRI0:   state_in = S_RD;
         S_RD:     state_in = stat.tri_more ? S_EDGE : S_FIN;
         S_EDGE:   state_in = S_CRP;
         S_CRP: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               idx_in = idx_wrap ? 2'd0 : idx_step;
               if (idx_wrap) state_in = S_CRQ;
            end
         end
         S_CRQ: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               idx_in = idx_wrap ? 2'd0 : idx_step;
               if (idx_wrap) state_in = S_DET;
            end
         end
         S_DET: begin
            idx_in = idx_wrap ? 2'd0 : idx_step;
            if (idx_wrap) state_in = S_UU;
         end
         S_UU: begin
            idx_in = idx_wrap ? 2'd0 : idx_step;
            if (idx_wrap) state_in = S_VV;
         end
         S_VV: begin
            idx_in = idx_wrap ? 2'd0 : idx_step;
            if (idx_wrap) state_in = S_TT;
         end
         S_TT: begin
            idx_in = idx_wrap ? 2'd0 : idx_step;
            if (idx_wrap) state_in = S_TEST;
         end
         S_TEST:   state_in = stat.hit ? S_CRC : S_NEXT;
         S_CRC: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               idx_in = idx_wrap ? 2'd0 : idx_step;
               if (idx_wrap) state_in = S_NORM;
            end
         end
         S_NORM:   if (!stat.norm_big) state_in = S_SS;
         S_SS: begin
            idx_in = idx_wrap ? 2'd0 : idx_step;
            if (idx_wrap) state_in = S_NSQL;
         end
         S_NSQL: begin
            cnt_in   = '0;
            state_in = S_NSQS;
         end
         S_NSQS: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(SQRT_STEPS - 1)) state_in = S_LL;
         end
         S_LL:     state_in = S_DVL;
         S_DVL: begin
            cnt_in   = '0;
            state_in = S_DVS;
         end
         S_DVS: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) state_in = S_DVE;
         end
         S_DVE: begin
            idx_in   = idx_wrap ? 2'd0 : idx_step;
            state_in = idx_wrap ? S_KK : S_DVL;
         end
         S_KK: begin
            idx_in = idx_wrap ? 2'd0 : idx_step;
            if (idx_wrap) state_in = S_REFL;
         end
         S_REFL: begin
            ph_in = ~ph_ff;
            if (ph_ff) begin
               idx_in = idx_wrap ? 2'd0 : idx_step;
               if (idx_wrap) state_in = S_NEXT;
            end
         end
         S_NEXT:   state_in = S_RD;
         S_FIN:    state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         ph_ff    <= 1'b0;
         cnt_ff   <= '0;
         cmd_ff   <= '{op: OP_NOP, idx: 2'd0, ph: 1'b0};
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         ph_ff    <= ph_in;
         cnt_ff   <= cnt_in;
         cmd_ff   <= '{op: op_of(state_in), idx: idx_in, ph: ph_in};
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign cmd  = cmd_ff;
   assign busy = busy_ff;

endmodule

// ===== hdl/psb_dp.sv =====
// Datapath: triangle store, shared multiplier, square root and divider steps.
module psb_dp #(
   parameter int MAX_TRIANGLES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  psb_pkg::req_item_type req,
   input  psb_pkg::cfg_type      cfg,
   input  psb_pkg::cmd_type      cmd,
   output psb_pkg::stat_type     stat,
   output logic                  rsp_strobe,
   output psb_pkg::rsp_item_type rsp
);
   import psb_pkg::*;

   localparam int CW = $clog2(MAX_TRIANGLES + 1);
   localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam logic signed [63:0] COMP_MAX = (64'sd1 <<< (COMP_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] COMP_MIN = -COMP_MAX - 64'sd1;
   localparam logic signed [63:0] LIFE_MAX = (64'sd1 <<< (LIFE_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] LIFE_MIN = -LIFE_MAX - 64'sd1;

   function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int s);
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      return (x + half) >>> s;
   endfunction

   function automatic logic signed [COMP_BITS-1:0] sat_comp(input logic signed [63:0] x);
      logic signed [63:0] y;
      y = (x > COMP_MAX) ? COMP_MAX : ((x < COMP_MIN) ? COMP_MIN : x);
      return y[COMP_BITS-1:0];
   endfunction

   function automatic logic signed [LIFE_BITS-1:0] sat_life(input logic signed [63:0] x);
      logic signed [63:0] y;
      y = (x > LIFE_MAX) ? LIFE_MAX : ((x < LIFE_MIN) ? LIFE_MIN : x);
      return y[LIFE_BITS-1:0];
   endfunction

   function automatic logic [1:0] nxt(input logic [1:0] i);
      case (i)
         2'd0:    return 2'd1;
         2'd1:    return 2'd2;
         default: return 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] prv(input logic [1:0] i);
      case (i)
         2'd0:    return 2'd2;
         2'd1:    return 2'd0;
         default: return 2'd1;
      endcase
   endfunction

   // triangle store
   logic [VEC_BITS-1:0] mem_a [MAX_TRIANGLES];
   logic [VEC_BITS-1:0] mem_b [MAX_TRIANGLES];
   logic [VEC_BITS-1:0] mem_c [MAX_TRIANGLES];
   logic [VEC_BITS-1:0] rd_a_ff, rd_b_ff, rd_c_ff;

   // control
   logic [CW-1:0]       count_ff, tri_idx_ff;
   logic [HIT_BITS-1:0] hits_ff;
   logic                valid_ff, is_step_ff, full;

   // particle
   logic signed [COMP_BITS-1:0] pos_ff [3];
   logic signed [COMP_BITS-1:0] vel_ff [3];
   logic signed [COMP_BITS-1:0] np_ff  [3];
   logic signed [LIFE_BITS-1:0] life_ff;
   logic signed [20:0]          d_ff   [3];

   // triangle test
   logic signed [20:0] e0_ff [3];
   logic signed [20:0] e1_ff [3];
   logic signed [20:0] t_ff  [3];
   logic signed [30:0] p_ff  [3];
   logic signed [30:0] q_ff  [3];
   logic signed [54:0] det_ff, u_ff, v_ff, tt_ff;
   logic               det_neg_ff;
   logic [33:0]        epl_ff;

   // normal and reflection
   logic signed [42:0] cn_ff [3];
   logic [42:0]        mg_ff [3];
   logic [30:0]        l_ff;
   logic signed [13:0] n_ff  [3];
   logic signed [34:0] kk_ff;
   logic signed [23:0] w_ff;

   // iterative units
   logic [62:0] sq_x_ff, sq_r_ff, sq_b_ff, sq_rb;
   logic [42:0] rem_ff, dv_ff;
   logic [12:0] quo_ff;

   logic signed [63:0] acc_ff;
   rsp_item_type       rsp_ff;

   logic [1:0]         ci, ia, ib;
   logic signed [35:0] ma;
   logic signed [31:0] mb;
   logic signed [67:0] prod_full;
   logic signed [63:0] prod, mac_sum, cr_diff, mv_sum;
   logic signed [COMP_BITS-1:0] np_new;
   logic signed [24:0] refl_diff;
   logic signed [55:0] uv_sum;
   logic [54:0]        mac_abs;
   logic               hit;

   assign ci = cmd.idx;
   assign ia = cmd.ph ? prv(ci) : nxt(ci);
   assign ib = cmd.ph ? nxt(ci) : prv(ci);
   assign full = (count_ff == CW'(MAX_TRIANGLES));
   assign refl_diff = 25'(vel_ff[ci]) - 25'(w_ff);

   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.op)
         OP_MOVE: begin
            ma = 36'(vel_ff[ci]);
            mb = 32'(signed'({1'b0, cfg.time_step}));
         end
         OP_GRAV: begin
            ma = 36'(cfg.gravity_y);
            mb = 32'(signed'({1'b0, cfg.time_step}));
         end
         OP_DD: begin
            ma = 36'(d_ff[ci]);
            mb = 32'(d_ff[ci]);
         end
         OP_LEN: begin
            ma = 36'(signed'({1'b0, sq_r_ff[21:0]}));
            mb = 32'(signed'({1'b0, cfg.parallel_epsilon}));
         end
         OP_CRP: begin
            ma = 36'(d_ff[ia]);
            mb = 32'(e1_ff[ib]);
         end
         OP_CRQ: begin
            ma = 36'(t_ff[ia]);
            mb = 32'(e0_ff[ib]);
         end
         OP_CRC: begin
            ma = 36'(e0_ff[ia]);
            mb = 32'(e1_ff[ib]);
         end
         OP_DET: begin
            ma = 36'(p_ff[ci]);
            mb = 32'(e0_ff[ci]);
         end
         OP_UU: begin
            ma = 36'(p_ff[ci]);
            mb = 32'(t_ff[ci]);
         end
         OP_VV: begin
            ma = 36'(q_ff[ci]);
            mb = 32'(d_ff[ci]);
         end
         OP_TT: begin
            ma = 36'(q_ff[ci]);
            mb = 32'(e1_ff[ci]);
         end
         OP_SS: begin
            ma = 36'(signed'({1'b0, mg_ff[ci][29:0]}));
            mb = 32'(signed'({1'b0, mg_ff[ci][29:0]}));
         end
         OP_KK: begin
            ma = 36'(vel_ff[ci]);
            mb = 32'(n_ff[ci]);
         end
         OP_REFL: begin
            ma = cmd.ph ? 36'(refl_diff) : 36'(kk_ff);
            mb = cmd.ph ? 32'(signed'({1'b0, cfg.bounce_damping})) : 32'(n_ff[ci]);
         end
         default: begin
            ma = '0;
            mb = '0;
         end
      endcase
   end

   assign prod_full = ma * mb;
   assign prod      = prod_full[63:0];
   assign mac_sum   = (ci == 2'd0) ? prod : acc_ff + prod;
   assign cr_diff   = acc_ff - prod;
   assign mac_abs   = mac_sum[63] ? 55'(-mac_sum) : 55'(mac_sum);
   assign mv_sum    = 64'(pos_ff[ci]) + rnd(prod, 16);
   assign np_new    = sat_comp(mv_sum);
   assign sq_rb     = sq_r_ff + sq_b_ff;
   assign uv_sum    = 56'(u_ff) + 56'(v_ff);

   // det_ff holds |det|; u, v, t already carry the sign flip
   assign hit = (det_ff != '0) && (det_ff >= 55'(signed'({1'b0, epl_ff})))
             && (u_ff >= 0) && (u_ff <= det_ff) && (v_ff >= 0)
             && (uv_sum <= 56'(det_ff)) && (tt_ff >= 0) && (tt_ff <= det_ff);

   assign stat.is_step  = is_step_ff;
   assign stat.acc_zero = (acc_ff == '0);
   assign stat.hit      = hit;
   assign stat.norm_big = (mg_ff[0][42:30] != '0) || (mg_ff[1][42:30] != '0)
                       || (mg_ff[2][42:30] != '0);
   assign stat.tri_more = (tri_idx_ff < count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         tri_idx_ff <= '0;
         hits_ff    <= '0;
         valid_ff   <= 1'b0;
         is_step_ff <= 1'b0;
      end else begin
         valid_ff <= (cmd.op == OP_FINISH) || (cmd.op == OP_APPEND);
         if (accept) begin
            is_step_ff <= req.req_type;
            hits_ff    <= '0;
         end
         case (cmd.op)
            OP_APPEND:    if (!full) count_ff <= count_ff + 1'b1;
            OP_TRI_FIRST: tri_idx_ff <= '0;
            OP_NEXT:      tri_idx_ff <= tri_idx_ff + 1'b1;
            OP_TEST:      if (hit) hits_ff <= hits_ff + 1'b1;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int k = 0; k < 3; k++) begin
            pos_ff[k] <= req.position[k*COMP_BITS +: COMP_BITS];
            vel_ff[k] <= req.velocity[k*COMP_BITS +: COMP_BITS];
         end
         life_ff <= req.lifetime;
      end
      if (accept && !req.req_type && !full) begin
         mem_a[count_ff[AW-1:0]] <= req.corner_a;
         mem_b[count_ff[AW-1:0]] <= req.corner_b;
         mem_c[count_ff[AW-1:0]] <= req.corner_c;
      end
      case (cmd.op)
         OP_APPEND: begin
            rsp_ff <= '{new_position: '0, new_velocity: '0, new_lifetime: '0,
                        hit_count: '0, status: full};
         end
         OP_MOVE: begin
            np_ff[ci] <= np_new;
            d_ff[ci]  <= 21'(np_new) - 21'(pos_ff[ci]);
         end
         OP_GRAV: begin
            vel_ff[1] <= sat_comp(64'(vel_ff[1]) + rnd(prod, 16));
            life_ff   <= sat_life(64'(life_ff) - rnd(64'(cfg.time_step), 4));
         end
         OP_DD, OP_SS: acc_ff <= mac_sum;
         OP_SQ_LOAD: begin
            sq_x_ff <= acc_ff[62:0];
            sq_r_ff <= '0;
            sq_b_ff <= 63'd1 << 60;
         end
         OP_SQ_STEP: begin
            if (sq_x_ff >= sq_rb) begin
               sq_x_ff <= sq_x_ff - sq_rb;
               sq_r_ff <= (sq_r_ff >> 1) + sq_b_ff;
            end else begin
               sq_r_ff <= sq_r_ff >> 1;
            end
            sq_b_ff <= sq_b_ff >> 2;
         end
         OP_LEN: begin
            epl_ff <= prod[33:0];
         end
         OP_RD: begin
            rd_a_ff <= mem_a[tri_idx_ff[AW-1:0]];
            rd_b_ff <= mem_b[tri_idx_ff[AW-1:0]];
            rd_c_ff <= mem_c[tri_idx_ff[AW-1:0]];
         end
         OP_EDGE: begin
            for (int k = 0; k < 3; k++) begin
               e0_ff[k] <= 21'(signed'(rd_b_ff[k*COMP_BITS +: COMP_BITS]))
                         - 21'(signed'(rd_a_ff[k*COMP_BITS +: COMP_BITS]));
               e1_ff[k] <= 21'(signed'(rd_c_ff[k*COMP_BITS +: COMP_BITS]))
                         - 21'(signed'(rd_a_ff[k*COMP_BITS +: COMP_BITS]));
               t_ff[k]  <= 21'(pos_ff[k])
                         - 21'(signed'(rd_a_ff[k*COMP_BITS +: COMP_BITS]));
            end
         end
         OP_CRP: begin
            if (cmd.ph) p_ff[ci] <= 31'(rnd(cr_diff, 12));
            else        acc_ff   <= prod;
         end
         OP_CRQ: begin
            if (cmd.ph) q_ff[ci] <= 31'(rnd(cr_diff, 12));
            else        acc_ff   <= prod;
         end
         OP_CRC: begin
            if (cmd.ph) begin
               cn_ff[ci] <= 43'(cr_diff);
               mg_ff[ci] <= cr_diff[63] ? 43'(-cr_diff) : 43'(cr_diff);
            end else begin
               acc_ff <= prod;
            end
         end
         OP_DET: begin
            acc_ff <= mac_sum;
            if (ci == 2'd2) begin
               det_ff     <= mac_abs;
               det_neg_ff <= mac_sum[63];
            end
         end
         OP_UU: begin
            acc_ff <= mac_sum;
            if (ci == 2'd2) u_ff <= det_neg_ff ? -55'(mac_sum) : 55'(mac_sum);
         end
         OP_VV: begin
            acc_ff <= mac_sum;
            if (ci == 2'd2) v_ff <= det_neg_ff ? -55'(mac_sum) : 55'(mac_sum);
         end
         OP_TT: begin
            acc_ff <= mac_sum;
            if (ci == 2'd2) tt_ff <= det_neg_ff ? -55'(mac_sum) : 55'(mac_sum);
         end
         OP_NORM: begin
            if (stat.norm_big) begin
               for (int k = 0; k < 3; k++) mg_ff[k] <= mg_ff[k] >> 1;
            end
         end
         OP_LL: l_ff <= sq_r_ff[30:0];
         OP_DIV_LOAD: begin
            rem_ff <= {1'b0, mg_ff[ci][29:0], 12'd0} + 43'(l_ff >> 1);
            dv_ff  <= {l_ff, 12'd0};
            quo_ff <= '0;
         end
         OP_DIV_STEP: begin
            if (rem_ff >= dv_ff) begin
               rem_ff <= rem_ff - dv_ff;
               quo_ff <= {quo_ff[11:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[11:0], 1'b0};
            end
            dv_ff <= dv_ff >> 1;
         end
         OP_DIV_END: begin
            if (l_ff == '0)      n_ff[ci] <= '0;
            else if (cn_ff[ci] < 0) n_ff[ci] <= -14'(signed'({1'b0, quo_ff}));
            else                 n_ff[ci] <= 14'(signed'({1'b0, quo_ff}));
         end
         OP_KK: begin
            acc_ff <= mac_sum;
            if (ci == 2'd2) kk_ff <= 35'(mac_sum);
         end
         OP_REFL: begin
            if (cmd.ph) begin
               vel_ff[ci] <= sat_comp(rnd(prod, 16));
               np_ff[ci]  <= pos_ff[ci];
            end else begin
               w_ff <= 24'(rnd(prod, 23));
            end
         end
         OP_FINISH: begin
            rsp_ff <= '{new_position: {np_ff[2], np_ff[1], np_ff[0]},
                        new_velocity: {vel_ff[2], vel_ff[1], vel_ff[0]},
                        new_lifetime: life_ff, hit_count: hits_ff, status: 1'b0};
         end
         default: ;
      endcase
   end

   assign rsp_strobe = valid_ff;
   assign rsp        = rsp_ff;

endmodule

// ===== hdl/particle_step_triangle_bounce.sv =====
// Top level: configuration registers, sequencer and datapath of the particle step.
//
// A request is taken when start is high and busy is low; its result appears on
// rsp_data for one cycle with rsp_strobe and cannot be held off. A step runs longer
// with more stored triangles and more triangles hit, set by the single shared
// multiplier and the one-bit-per-cycle square root (31 steps) and divider
// (13 steps); a zero-length move skips the triangle walk. Configuration writes
// must happen while busy is low.
module particle_step_triangle_bounce #(
   parameter int MAX_TRIANGLES = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  psb_pkg::req_item_type                req_data,
   output logic                                 rsp_strobe,
   output psb_pkg::rsp_item_type                rsp_data,
   input  logic                                 csr_we,
   input  logic [psb_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [psb_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import psb_pkg::*;

   cfg_type  cfg_ff;
   cmd_type  cmd;
   stat_type stat;
   logic     accept;

   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{time_step: TIME_STEP_RST, gravity_y: GRAVITY_Y_RST,
                     bounce_damping: DAMPING_RST, parallel_epsilon: EPSILON_RST};
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIME_STEP:        cfg_ff.time_step        <= csr_wdata[15:0];
            CSR_GRAVITY_Y:        cfg_ff.gravity_y        <= csr_wdata;
            CSR_BOUNCE_DAMPING:   cfg_ff.bounce_damping   <= csr_wdata[15:0];
            CSR_PARALLEL_EPSILON: cfg_ff.parallel_epsilon <= csr_wdata[11:0];
            default:              ;
         endcase
      end
   end

   psb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   psb_dp #(
      .MAX_TRIANGLES (MAX_TRIANGLES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_data)
   );

endmodule

// ===== bench/particle_step_triangle_bounce_tb.sv =====
// Self-checking testbench for the particle step with triangle bounce block.
module particle_step_triangle_bounce_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import psb_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 290;
   localparam int QUIET_TAIL   = 40;
   localparam logic REQ_APPEND = 1'b0;
   localparam logic REQ_STEP   = 1'b1;
   localparam logic ST_OK      = 1'b0;
   localparam logic ST_FULL    = 1'b1;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_item_type req_data;
   logic rsp_strobe;
   rsp_item_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   particle_step_triangle_bounce dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // predictor state
   logic [VEC_BITS-1:0] tri_a [TABLE_DEPTH];
   logic [VEC_BITS-1:0] tri_b [TABLE_DEPTH];
   logic [VEC_BITS-1:0] tri_c [TABLE_DEPTH];
   int unsigned tri_count;
   cfg_type cfg;

   rsp_item_type pending_rsp[$];
   int errors;
   int steps_sent, appends_sent, refused_seen, hits_seen, rsp_seen;

   typedef longint vec3_type[3];

   function automatic longint rnd(longint x, int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint sat(longint x, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      return x > hi ? hi : (x < -hi - 1 ? -hi - 1 : x);
   endfunction

   function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void unpack3(logic [VEC_BITS-1:0] w, output vec3_type v);
      logic signed [COMP_BITS-1:0] c;
      for (int i = 0; i < 3; i++) begin
         c = w[i*COMP_BITS +: COMP_BITS];
         v[i] = c;
      end
   endfunction

   function automatic logic [VEC_BITS-1:0] pack3(longint x, longint y, longint z);
      logic [COMP_BITS-1:0] cx, cy, cz;
      cx = x[COMP_BITS-1:0];
      cy = y[COMP_BITS-1:0];
      cz = z[COMP_BITS-1:0];
      return {cz, cy, cx};
   endfunction

   function automatic void cross3(vec3_type a, vec3_type b, output vec3_type r);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
   endfunction

   function automatic longint dot3(vec3_type a, vec3_type b);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
   endfunction

   function automatic bit segment_hits(vec3_type o, vec3_type d, longint unsigned len,
                                       vec3_type a, vec3_type e0, vec3_type e1);
      vec3_type p, q, t, c;
      longint det, u, v, tt;
      longint unsigned mag;
      cross3(d, e1, c);
      for (int i = 0; i < 3; i++) p[i] = rnd(c[i], 12);
      det = dot3(e0, p);
      mag = det < 0 ? -det : det;
      if (det == 0 || mag < longint'(cfg.parallel_epsilon) * len) return 1'b0;
      for (int i = 0; i < 3; i++) t[i] = o[i] - a[i];
      cross3(t, e0, c);
      for (int i = 0; i < 3; i++) q[i] = rnd(c[i], 12);
      u = dot3(t, p);
      v = dot3(d, q);
      tt = dot3(e1, q);
      if (det < 0) begin
         det = -det; u = -u; v = -v; tt = -tt;
      end
      return u >= 0 && u <= det && v >= 0 && u + v <= det && tt >= 0 && tt <= det;
   endfunction

   function automatic void face_normal(vec3_type e0, vec3_type e1, output vec3_type n);
      vec3_type c;
      longint unsigned m[3];
      longint unsigned mx, sum, l;
      int s;
      mx = 0; sum = 0; s = 0;
      cross3(e0, e1, c);
      for (int i = 0; i < 3; i++) begin
         m[i] = c[i] < 0 ? -c[i] : c[i];
         if (m[i] > mx) mx = m[i];
      end
      while ((mx >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < 3; i++) begin
         m[i] >>= s;
         sum += m[i] * m[i];
      end
      l = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
         if (l == 0) n[i] = 0;
         else begin
            n[i] = longint'((m[i] * 4096 + l / 2) / l);
            if (c[i] < 0) n[i] = -n[i];
         end
      end
   endfunction

   function automatic rsp_item_type particle_update(req_item_type r);
      rsp_item_type res;
      vec3_type pos, vel, np, d, a, b, c, e0, e1, n;
      longint dt, life, kd, w;
      longint unsigned l2, len;
      int hits;
      res = '0;
      if (r.req_type == REQ_APPEND) begin
         if (tri_count >= TABLE_DEPTH) res.status = ST_FULL;
         else begin
            tri_a[tri_count] = r.corner_a;
            tri_b[tri_count] = r.corner_b;
            tri_c[tri_count] = r.corner_c;
            tri_count++;
         end
         return res;
      end
      dt = cfg.time_step;
      unpack3(r.position, pos);
      unpack3(r.velocity, vel);
      life = r.lifetime;
      for (int i = 0; i < 3; i++) begin
         np[i] = sat(pos[i] + rnd(vel[i] * dt, 16), COMP_BITS);
         d[i] = np[i] - pos[i];
      end
      vel[1] = sat(vel[1] + rnd(longint'(cfg.gravity_y) * dt, 16), COMP_BITS);
      life = sat(life - rnd(dt, 4), LIFE_BITS);
      l2 = dot3(d, d);
      hits = 0;
      if (l2 != 0) begin
         len = isqrt(l2);
         for (int k = 0; k < tri_count; k++) begin
            unpack3(tri_a[k], a);
            unpack3(tri_b[k], b);
            unpack3(tri_c[k], c);
            for (int i = 0; i < 3; i++) begin
               e0[i] = b[i] - a[i];
               e1[i] = c[i] - a[i];
            end
            if (!segment_hits(pos, d, len, a, e0, e1)) continue;
            hits++;
            face_normal(e0, e1, n);
            kd = dot3(vel, n);
            for (int i = 0; i < 3; i++) begin
               w = rnd(2 * n[i] * kd, 24);
               vel[i] = sat(rnd((vel[i] - w) * longint'(cfg.bounce_damping), 16),
                            COMP_BITS);
               np[i] = pos[i];
            end
         end
      end
      res.new_position = pack3(np[0], np[1], np[2]);
      res.new_velocity = pack3(vel[0], vel[1], vel[2]);
      res.new_lifetime = life[LIFE_BITS-1:0];
      res.hit_count = hits[HIT_BITS-1:0];
      res.status = ST_OK;
      return res;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_strobe) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status != want.status || rsp_data.hit_count != want.hit_count ||
                rsp_data.new_lifetime != want.new_lifetime ||
                rsp_data.new_position != want.new_position ||
                rsp_data.new_velocity != want.new_velocity) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch exp: st=%0d hits=%0d life=%h pos=%h vel=%h",
                           want.status, want.hit_count, want.new_lifetime,
                           want.new_position, want.new_velocity);
                  $display("         got: st=%0d hits=%0d life=%h pos=%h vel=%h",
                           rsp_data.status, rsp_data.hit_count, rsp_data.new_lifetime,
                           rsp_data.new_position, rsp_data.new_velocity);
               end
            end
            if (rsp_data.status == ST_FULL) refused_seen++;
            hits_seen += rsp_data.hit_count;
         end
      end
   end

   // caller is at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(req_item_type r, bit typed, rsp_item_type typed_rsp);
      rsp_item_type p;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      p = particle_update(r);
      pending_rsp.push_back(typed ? typed_rsp : p);
      if (r.req_type == REQ_STEP) steps_sent++;
      else appends_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic program_regs(cfg_type c);
      logic [CSR_DATA_BITS-1:0] vals[4];
      logic [CSR_IDX_BITS-1:0] idx[4];
      idx = '{CSR_TIME_STEP, CSR_GRAVITY_Y, CSR_BOUNCE_DAMPING, CSR_PARALLEL_EPSILON};
      vals = '{CSR_DATA_BITS'(c.time_step), CSR_DATA_BITS'(c.gravity_y),
               CSR_DATA_BITS'(c.bounce_damping), CSR_DATA_BITS'(c.parallel_epsilon)};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(negedge clock);
      end
      csr_we <= 1'b0;
      cfg = c;
   endtask

   function automatic longint rand_signed(int lo, int hi);
      return longint'(lo) + longint'($urandom_range(hi - lo, 0));
   endfunction

   function automatic req_item_type random_request(bit want_append);
      req_item_type r;
      longint s, y0;
      r = {1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
      r.req_type = want_append ? REQ_APPEND : REQ_STEP;
      if ($urandom_range(9, 0) < 7) begin
         if (want_append) begin
            s = rand_signed(4096, 409600);
            y0 = rand_signed(-3000, 3000);
            r.corner_a = pack3(-s, y0 + rand_signed(-2000, 2000), -s);
            r.corner_b = pack3(s, y0 + rand_signed(-2000, 2000), -s);
            r.corner_c = pack3(rand_signed(-4096, 4096), y0 + rand_signed(-2000, 2000), s);
         end else begin
            r.position = pack3(rand_signed(-40960, 40960), rand_signed(0, 9000),
                               rand_signed(-40960, 40960));
            r.velocity = pack3(rand_signed(-20000, 20000), rand_signed(-500000, -20000),
                               rand_signed(-20000, 20000));
         end
      end
      return r;
   endfunction

   typedef struct {
      req_item_type req;
      bit typed;
      rsp_item_type rsp;
   } stim_row_type;

   stim_row_type directed[$];

   function automatic void add_row(req_item_type r, bit typed);
      stim_row_type row;
      row.req = r;
      row.typed = typed;
      row.rsp = '0;
      directed.push_back(row);
   endfunction

   function automatic void build_directed();
      localparam longint CMAX = (1 <<< (COMP_BITS - 1)) - 1;
      localparam longint CMIN = -(1 <<< (COMP_BITS - 1));
      req_item_type r;
      r = '0; r.req_type = REQ_STEP;
      add_row(r, 1'b0);                                   // empty table, no motion
      r.velocity = pack3(0, -40960, 0); r.position = pack3(0, 200, 0);
      add_row(r, 1'b0);                                   // empty table, falling
      r = '0; r.req_type = REQ_APPEND;                    // floor
      r.corner_a = pack3(-409600, 0, -409600);
      r.corner_b = pack3(409600, 0, -409600);
      r.corner_c = pack3(0, 0, 409600);
      r.position = '1; r.velocity = '1; r.lifetime = '1;
      add_row(r, 1'b1);
      r = '0; r.req_type = REQ_STEP;                      // falls through floor
      r.position = pack3(100, 300, -50); r.velocity = pack3(4096, -81920, 2048);
      r.lifetime = 20'sd40960;
      add_row(r, 1'b0);
      r.velocity = pack3(0, 0, 0);                        // zero move, only gravity
      add_row(r, 1'b0);
      r.position = pack3(100, -300, -50); r.velocity = pack3(0, 81920, 0);
      add_row(r, 1'b0);                                   // from below
      r = '0; r.req_type = REQ_APPEND;                    // degenerate, all corners equal
      r.corner_a = pack3(5, 5, 5); r.corner_b = r.corner_a; r.corner_c = r.corner_a;
      add_row(r, 1'b1);
      r.corner_a = pack3(0, 4096, 0); r.corner_b = pack3(8192, 4096, 0);
      r.corner_c = pack3(16384, 4096, 0);                 // collinear
      add_row(r, 1'b1);
      r = '0; r.req_type = REQ_APPEND;                    // vertical wall, parallel to a fall
      r.corner_a = pack3(0, -409600, -409600); r.corner_b = pack3(0, 409600, -409600);
      r.corner_c = pack3(0, 0, 409600);
      add_row(r, 1'b1);
      r = '0; r.req_type = REQ_STEP;
      r.position = pack3(0, 300, 0); r.velocity = pack3(0, -81920, 0);
      add_row(r, 1'b0);                                   // touches wall and floor
      r.position = pack3(CMAX, CMAX, CMAX); r.velocity = pack3(CMAX, CMAX, CMAX);
      r.lifetime = 20'sh80000;
      add_row(r, 1'b0);                                   // saturate high, life low
      r.position = pack3(CMIN, CMIN, CMIN); r.velocity = pack3(CMIN, CMIN, CMIN);
      r.lifetime = 20'sh7FFFF;
      add_row(r, 1'b0);
      r.position = pack3(-200, 500, 300); r.velocity = pack3(CMAX, CMIN, CMAX);
      add_row(r, 1'b0);
      r.corner_a = '1; r.corner_b = '1; r.corner_c = '1;
      r.position = '1; r.velocity = '1; r.lifetime = '1;
      add_row(r, 1'b0);
   endfunction

   int gap;
   cfg_type phase_cfg[4];

   initial begin
      req_item_type r;
      rsp_item_type zero_rsp;
      bit idle_on;
      int per_phase, sent;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      errors = 0; steps_sent = 0; appends_sent = 0;
      refused_seen = 0; hits_seen = 0; rsp_seen = 0;
      tri_count = 0;
      cfg = '{TIME_STEP_RST, GRAVITY_Y_RST, DAMPING_RST, EPSILON_RST};
      zero_rsp = '0;
      build_directed();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         send_request(directed[i].req, directed[i].typed, directed[i].rsp);
         if ($urandom_range(1, 0)) begin
            start <= 1'b0;
            repeat ($urandom_range(11, 1)) @(negedge clock);
         end
      end
      drain();

      phase_cfg[0] = '{16'hFFFF, 20'sh7FFFF, 16'd0, 12'd0};
      phase_cfg[1] = '{16'd0, 20'sh80000, 16'hFFFF, 12'hFFF};
      phase_cfg[2] = '{16'd1092, -20'sd16384, 16'd45875, 12'd1};
      phase_cfg[3] = '{16'($urandom_range(4000, 200)), 20'($urandom_range(60000, 0)) - 20'sd30000,
                       16'($urandom), 12'($urandom_range(40, 0))};
      per_phase = RANDOM_ITEMS / 4;
      sent = 0;
      for (int ph = 0; ph < 4; ph++) begin
         program_regs(phase_cfg[ph]);
         for (int k = 0; k < per_phase; k++) begin
            r = random_request($urandom_range(9, 0) < 3);
            send_request(r, 1'b0, zero_rsp);
            sent++;
            idle_on = sent < RANDOM_ITEMS - QUIET_TAIL;
            if (idle_on && $urandom_range(2, 0) == 0) begin
               start <= 1'b0;
               repeat ($urandom_range(11, 1)) @(negedge clock);
            end
         end
         drain();
      end

      repeat (50) @(negedge clock);
      $display("ran %0d steps and %0d triangle loads over 5 register settings",
               steps_sent, appends_sent);
      $display("saw %0d results, %0d triangle hits, %0d refused loads",
               rsp_seen, hits_seen, refused_seen);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end

endmodule
